@@ design/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 11;
  localparam int ORDER_W  = 4;
  localparam int STATUS_W = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_NO_FIT   = 2'd1;
  localparam status_t STATUS_BAD_FREE = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_CK,
    ST_A_SPLIT,
    ST_F_RD,
    ST_F_CK,
    ST_F_BRD,
    ST_F_BCK,
    ST_F_MARK,
    ST_DONE
  } state_t;

endpackage

@@ design/bba_ifs.sv @@
// ----------------------------------------------------------------------------
// bba channel interfaces
// Request, response and base register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [bba_pkg::SIZE_W-1:0] request_size;
  logic [bba_pkg::ADDR_W-1:0] free_address;
  modport source (output valid, action, request_size, free_address, input ready);
  modport sink   (input valid, action, request_size, free_address, output ready);
endinterface

interface bba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::ADDR_W-1:0]  block_address;
  logic [bba_pkg::ORDER_W-1:0] block_order;
  bba_pkg::status_t            status;
  modport source (output valid, block_address, block_order, status, input ready);
  modport sink   (input valid, block_address, block_order, status, output ready);
endinterface

interface bba_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bba_pkg::ADDR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ design/bba_sizer.sv @@
// ----------------------------------------------------------------------------
// bba_sizer
// Rounds a request size up to a block order (minimum 1) and flags bad sizes.
// ----------------------------------------------------------------------------
module bba_sizer #(
  parameter int MaxOrder = 10
) (
  input  logic [bba_pkg::SIZE_W-1:0]    size,
  output logic [$clog2(MaxOrder+1)-1:0] want,
  output logic                          bad
);
  import bba_pkg::*;

  localparam int OW = $clog2(MaxOrder + 1);

  logic [SIZE_W-1:0] sm1;
  logic [3:0]        blen;

  // bit length of size-1 is the ceiling log2
  always_comb begin
    sm1  = size - SIZE_W'(1);
    blen = 4'd0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (sm1[i]) blen = 4'(i + 1);
    end
    if (blen == 4'd0) blen = 4'd1;
  end

  assign bad  = (size == '0) || (32'(size) > (32'd1 << MaxOrder));
  assign want = OW'(blen);

endmodule

@@ design/buddy_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Buddy allocator over 2^MaxOrder units with a free-node bitmap and an order
// table, each held in a memory with one read and one write port, walked by a small
// sequencer.
// After reset the block runs a clearing pass over its memories and takes no
// request meanwhile (base writes are taken). One request is handled at a
// time. An allocate scans the bitmap one node at a time, from the first node
// of the wanted order upward in order; a free merges upward one level at a
// time while the buddy is free.
module buddy_block_allocator_top #(
  parameter int MaxOrder = 10
) (
  input logic clk,
  input logic rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp,
  bba_cfg_if.sink   cfg
);
  import bba_pkg::*;

  localparam int NW = MaxOrder;
  localparam int OW = $clog2(MaxOrder + 1);
  localparam int TW = MaxOrder - 1;

  state_t state, state_next;

  logic [ADDR_W-1:0] base;
  logic [OW-1:0]     lvl;
  logic [OW-1:0]     want;
  logic [NW-1:0]     idx;
  logic [NW-1:0]     off;
  logic [NW-1:0]     ccnt;

  logic [ADDR_W-1:0] res_addr;
  logic [OW-1:0]     res_order;
  status_t           res_status;

  logic              out_valid;
  logic [ADDR_W-1:0] out_addr;
  logic [OW-1:0]     out_order;
  status_t           out_status;

  logic              fmap [2**NW];
  logic [OW-1:0]     otab [2**TW];
  logic              fmap_rd;
  logic [OW-1:0]     otab_rd;

  logic [NW-1:0] fmap_ra, fmap_wa;
  logic          fmap_we, fmap_wd;
  logic [TW-1:0] otab_ra, otab_wa;
  logic          otab_we;
  logic [OW-1:0] otab_wd;

  logic [OW-1:0]     sz_want;
  logic              sz_bad;
  logic [ADDR_W-1:0] rel;
  logic              rel_bad;
  logic [NW:0]       idx_inc;
  logic              lvl_last;
  logic [NW-1:0]     buddy;

  function automatic logic [NW-1:0] node_of(input logic [OW-1:0] k, input logic [NW-1:0] o);
    node_of = (NW'(1) << (MaxOrder - int'(k))) | (o >> k);
  endfunction

  bba_sizer #(.MaxOrder(MaxOrder)) u_sizer (
    .size (req.request_size),
    .want (sz_want),
    .bad  (sz_bad)
  );

  assign rel      = req.free_address - base;
  assign rel_bad  = ((rel >> MaxOrder) != '0) || rel[0];
  assign idx_inc  = {1'b0, idx} + (NW+1)'(1);
  assign lvl_last = ({1'b0, idx} & idx_inc) == '0;
  assign buddy    = node_of(lvl, off ^ (NW'(1) << lvl));

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid         = out_valid;
  assign rsp.block_address = out_addr;
  assign rsp.block_order   = ORDER_W'(out_order);
  assign rsp.status        = out_status;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    fmap_ra    = idx;
    fmap_we    = 1'b0;
    fmap_wa    = idx;
    fmap_wd    = 1'b0;
    otab_ra    = off[NW-1:1];
    otab_we    = 1'b0;
    otab_wa    = off[NW-1:1];
    otab_wd    = '0;
    unique case (state)
      ST_CLEAR: begin
        fmap_we = 1'b1;
        fmap_wa = ccnt;
        fmap_wd = (ccnt == NW'(1));
        otab_we = 1'b1;
        otab_wa = ccnt[TW-1:0];
        if (ccnt == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) begin
          if (req.action == ACT_ALLOC) state_next = sz_bad ? ST_DONE : ST_A_RD;
          else                         state_next = rel_bad ? ST_DONE : ST_F_RD;
        end
      end
      ST_A_RD: state_next = ST_A_CK;
      ST_A_CK: begin
        if (fmap_rd) begin
          fmap_we    = 1'b1;
          state_next = ST_A_SPLIT;
        end else if (lvl_last && lvl == OW'(MaxOrder)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_A_RD;
        end
      end
      ST_A_SPLIT: begin
        if (lvl > want) begin
          fmap_we = 1'b1;
          fmap_wa = node_of(lvl - OW'(1), off | (NW'(1) << (lvl - OW'(1))));
          fmap_wd = 1'b1;
        end else begin
          otab_we    = 1'b1;
          otab_wd    = want;
          state_next = ST_DONE;
        end
      end
      ST_F_RD: state_next = ST_F_CK;
      ST_F_CK: begin
        if (otab_rd == '0) begin
          state_next = ST_DONE;
        end else begin
          otab_we    = 1'b1;
          state_next = ST_F_BRD;
        end
      end
      ST_F_BRD: begin
        fmap_ra    = buddy;
        state_next = (lvl == OW'(MaxOrder)) ? ST_F_MARK : ST_F_BCK;
      end
      ST_F_BCK: begin
        if (fmap_rd) begin
          fmap_we    = 1'b1;
          fmap_wa    = buddy;
          state_next = ST_F_BRD;
        end else begin
          state_next = ST_F_MARK;
        end
      end
      ST_F_MARK: begin
        fmap_we    = 1'b1;
        fmap_wa    = node_of(lvl, off);
        fmap_wd    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (fmap_we) fmap[fmap_wa] <= fmap_wd;
    fmap_rd <= fmap[fmap_ra];
    if (otab_we) otab[otab_wa] <= otab_wd;
    otab_rd <= otab[otab_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cfg.valid) begin
      base <= cfg.data;
    end
  end

  // datapath under the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      ccnt <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: ccnt <= ccnt + NW'(1);
        ST_IDLE: begin
          off        <= rel[NW-1:0];
          want       <= sz_want;
          lvl        <= sz_want;
          idx        <= NW'(1) << (MaxOrder - int'(sz_want));
          res_addr   <= '0;
          res_order  <= '0;
          res_status <= (req.action == ACT_ALLOC) ? STATUS_NO_FIT : STATUS_BAD_FREE;
        end
        ST_A_CK: begin
          if (fmap_rd) begin
            off <= NW'({1'b0, idx} << lvl);
          end else if (lvl_last) begin
            if (lvl != OW'(MaxOrder)) begin
              lvl <= lvl + OW'(1);
              idx <= NW'(idx_inc >> 2);
            end
          end else begin
            idx <= idx_inc[NW-1:0];
          end
        end
        ST_A_SPLIT: begin
          if (lvl > want) begin
            lvl <= lvl - OW'(1);
          end else begin
            res_addr   <= base + ADDR_W'(off);
            res_order  <= want;
            res_status <= STATUS_OK;
          end
        end
        ST_F_CK: begin
          lvl       <= otab_rd;
          res_order <= otab_rd;
        end
        ST_F_BCK: begin
          if (fmap_rd) begin
            off <= off & ~(NW'(1) << lvl);
            lvl <= lvl + OW'(1);
          end
        end
        ST_F_MARK: res_status <= STATUS_OK;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || rsp.ready)) begin
      out_valid  <= 1'b1;
      out_addr   <= res_addr;
      out_order  <= res_order;
      out_status <= res_status;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !req.ready)
    else $error("request taken during clearing pass");

  a_fail_is_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != STATUS_OK) |-> (rsp.block_order == '0 &&
      rsp.block_address == '0))
    else $error("failed transaction carries address or order");

  a_split_above_want: assert property (@(posedge clk) disable iff (rst)
    state == ST_A_SPLIT |-> lvl >= want)
    else $error("split went below wanted order");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_F_BRD || state == ST_F_BCK || state == ST_A_CK) |->
      (lvl <= OW'(MaxOrder) && lvl != '0))
    else $error("level out of range");

  a_split_from_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_A_SPLIT && $past(state) != ST_A_SPLIT) |-> $past(state) == ST_A_CK)
    else $error("split entered without a found block");

endmodule

@@ tb/sv/tb_buddy_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_top
// Drives allocate and free requests with random gaps and stalls, predicts
// every response with a local buddy model and checks it field by field.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int MAX_ORD = 10;
  localparam int UNITS = 1 << MAX_ORD;
  localparam int LIMIT = 15000000;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [ORDER_W-1:0] order;
    status_t            status;
  } alloc_rsp_t;

  class alloc_scoreboard;
    logic [31:0]  base;
    bit           free_map[UNITS];
    logic [3:0]   order_tab[UNITS/2];
    alloc_rsp_t   pending[$];
    int           errors;
    logic [31:0]  live[$];

    function new();
      base = 0;
      foreach (free_map[i]) free_map[i] = 0;
      foreach (order_tab[i]) order_tab[i] = 0;
      free_map[1] = 1;
      errors = 0;
    endfunction

    function int node(int k, logic [31:0] off);
      return ((1 << (MAX_ORD - k)) + (off >> k)) & (UNITS - 1);
    endfunction

    function alloc_rsp_t do_alloc(logic [10:0] size);
      alloc_rsp_t r;
      int want, k, cnt;
      logic [31:0] off;
      bit found;
      r = '{0, 0, STATUS_NO_FIT};
      found = 0;
      off = 0;
      if (size == 0 || size > UNITS) return r;
      want = 1;
      while ((1 << want) < size) want++;
      for (k = want; k <= MAX_ORD; k++) begin
        cnt = 1 << (MAX_ORD - k);
        for (int i = 0; i < cnt; i++)
          if (!found && free_map[cnt + i]) begin
            off = i << k;
            found = 1;
          end
        if (found) break;
      end
      if (!found) return r;
      free_map[node(k, off)] = 0;
      while (k > want) begin
        k--;
        free_map[node(k, off + (1 << k))] = 1;
      end
      order_tab[(off >> 1) & (UNITS/2 - 1)] = 4'(want);
      r = '{base + off, want, STATUS_OK};
      live.push_back(base + off);
      return r;
    endfunction

    function alloc_rsp_t do_free(logic [31:0] a);
      alloc_rsp_t r;
      logic [31:0] off;
      int ord, k;
      r = '{0, 0, STATUS_BAD_FREE};
      off = a - base;
      if (off >= UNITS || off[0]) return r;
      ord = order_tab[off >> 1];
      if (ord == 0 || ord > MAX_ORD) return r;
      order_tab[off >> 1] = 0;
      k = ord;
      while (k < MAX_ORD) begin
        if (!free_map[node(k, off ^ (1 << k))]) break;
        free_map[node(k, off ^ (1 << k))] = 0;
        off &= ~(32'd1 << k);
        k++;
      end
      free_map[node(k, off)] = 1;
      r = '{0, ord, STATUS_OK};
      return r;
    endfunction

    function void note_request(logic act, logic [10:0] size, logic [31:0] a);
      pending.push_back(act == ACT_ALLOC ? do_alloc(size) : do_free(a));
    endfunction

    function void check_response(alloc_rsp_t got);
      alloc_rsp_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.addr !== exp.addr || got.order !== exp.order ||
          got.status !== exp.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %h/%0d/%0d actual %h/%0d/%0d", exp.addr,
                   exp.order, exp.status, got.addr, got.order, got.status);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  bba_req_if req();
  bba_rsp_if rsp();
  bba_cfg_if cfg();
  alloc_scoreboard sb = new();
  int cycles = 0;
  int hold_off = 0;
  bit hold_req = 0;

  buddy_block_allocator_top #(.MaxOrder(MAX_ORD)) u_dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    req.valid = 0; req.action = 0; req.request_size = 0; req.free_address = 0;
    rsp.ready = 0; cfg.valid = 0; cfg.data = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int w;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp.ready <= 0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      repeat (w) @(posedge clk);
      rsp.ready <= 1;
      do @(posedge clk); while (!(rsp.valid && rsp.ready));
      sb.check_response('{rsp.block_address, rsp.block_order, rsp.status});
      rsp.ready <= 0;
    end
  end

  // valid stays high after an accept until the next call decides on a gap
  task automatic send_request(logic act, logic [10:0] size, logic [31:0] a, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 12) : 0;
    if (w > 0) begin
      req.valid <= 0;
      repeat (w) @(posedge clk);
    end
    req.valid <= 1; req.action <= act; req.request_size <= size;
    req.free_address <= a;
    do @(posedge clk); while (!req.ready);
    sb.note_request(act, size, a);
  endtask

  task automatic write_base(logic [31:0] v);
    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * UNITS + 40) @(posedge clk);
    cfg.valid <= 1; cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    sb.base = v;
    cfg.valid <= 0;
  endtask

  task automatic random_item(bit gaps);
    int r;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      int sh;
      sh = $urandom_range(0, 6);
      send_request(ACT_ALLOC, 11'($urandom_range(1, 1 << sh)), 0, gaps);
    end else if (r < 85 && sb.live.size() > 0) begin
      int j;
      j = $urandom_range(0, sb.live.size() - 1);
      a = sb.live[j];
      sb.live.delete(j);
      send_request(ACT_FREE, 11'($urandom), a, gaps);
    end else if (r < 92) begin
      send_request(ACT_ALLOC, 11'($urandom), 0, gaps);
    end else begin
      a = $urandom_range(0, 3) == 0 ? $urandom : sb.base + $urandom_range(0, UNITS + 8);
      send_request(ACT_FREE, 11'($urandom), a, gaps);
    end
  endtask

  initial begin
    logic [31:0] bases[4];
    bases = '{32'h0, 32'hFFFF_FE00, 32'h1234_5678, 32'hFFFF_FFFF};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes and special cases
    send_request(ACT_ALLOC, 0, 0, 0);
    send_request(ACT_ALLOC, 11'd1025, 0, 0);
    send_request(ACT_ALLOC, 11'h7FF, 0, 0);
    send_request(ACT_ALLOC, 11'd1024, 0, 0);
    send_request(ACT_ALLOC, 1, 0, 0);
    send_request(ACT_FREE, 0, 32'h0, 0);
    send_request(ACT_FREE, 0, 32'h0, 0);
    send_request(ACT_ALLOC, 1, 0, 0);
    send_request(ACT_ALLOC, 3, 0, 0);
    send_request(ACT_ALLOC, 2, 0, 0);
    send_request(ACT_FREE, 0, 32'h1, 0);
    send_request(ACT_FREE, 0, 32'h6, 0);
    send_request(ACT_FREE, 0, 32'd1024, 0);
    send_request(ACT_FREE, 0, 32'hFFFF_FFFE, 0);
    send_request(ACT_FREE, 0, 32'h4, 0);
    send_request(ACT_FREE, 0, 32'h2, 0);
    send_request(ACT_FREE, 0, 32'h0, 0);
    send_request(ACT_ALLOC, 11'd512, 0, 0);
    send_request(ACT_ALLOC, 11'd513, 0, 0);
    sb.live.delete();
    send_request(ACT_FREE, 0, 32'h0, 0);
    for (int ph = 0; ph < 4; ph++) begin
      write_base(bases[ph]);
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 310; n++) random_item(n % 100 > 20);
    end
    write_base($urandom);
    for (int n = 0; n < 20; n++) random_item(1);
    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * UNITS + 40) @(posedge clk);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
